>>> hw/rtl/bgfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgfs_pkg: shared types, widths and rounding helpers
// Fixed-point formats and arithmetic helpers used by the grasp face pipeline.
// ----------------------------------------------------------------------------
package bgfs_pkg;

    // Number formats: rotations are signed Q1.F, lengths signed 20-bit.
    localparam int QUAT_FRAC_BITS = 14;
    localparam int Q_W            = 16;
    localparam int LEN_W          = 20;

    // Divider: one quotient bit per stage, the quotient never exceeds 1.0.
    localparam int DIV_STEPS = QUAT_FRAC_BITS + 1;
    localparam int SQ_W      = 2 * Q_W;
    localparam int NUM_W     = SQ_W + 2;
    localparam int NORM_W    = SQ_W + 1;
    localparam int DVS_W     = NORM_W + 1;
    localparam int REM_W     = NORM_W + DIV_STEPS;
    localparam int PT_W      = Q_W + LEN_W;
    localparam int ACC_W     = 40;

    // Latencies of the pipeline sections, in register stages.
    localparam int QM_LAT  = DIV_STEPS + 3;
    localparam int CMP_LAT = 2;
    localparam int FP_LAT  = 3;

    typedef logic signed [Q_W-1:0]   t_q16;
    typedef logic signed [LEN_W-1:0] t_len;
    typedef logic signed [ACC_W-1:0] t_acc;
    typedef t_q16 t_mat [3][3];
    typedef t_q16 t_vec3q [3];
    typedef t_len t_vec3l [3];
    typedef t_acc t_vec3a [3];

    localparam t_q16 Q_ONE   = t_q16'(1 << QUAT_FRAC_BITS);
    localparam t_acc LEN_MAX = t_acc'((1 << (LEN_W - 1)) - 1);
    localparam t_acc LEN_MIN = -LEN_MAX - t_acc'(1);

    // Drop the fraction bits, rounding half away from zero.
    function automatic t_acc round_frac(input t_acc v);
        t_acc half;
        t_acc res;
        half = t_acc'(1) <<< (QUAT_FRAC_BITS - 1);
        if (v >= 0) begin
            res = (v + half) >>> QUAT_FRAC_BITS;
        end else begin
            res = -((-v + half) >>> QUAT_FRAC_BITS);
        end
        return res;
    endfunction

    // Saturate to the signed length range.
    function automatic t_len sat_len(input t_acc v);
        t_acc c;
        if (v > LEN_MAX) begin
            c = LEN_MAX;
        end else if (v < LEN_MIN) begin
            c = LEN_MIN;
        end else begin
            c = v;
        end
        return t_len'(c);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/best_grasp_face_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// best_grasp_face_select: grasp face and position from an object pose
// An object pose word (quaternion plus translation, camera frame) enters on
// the s_axis channel; the result word (approach direction, grasp position)
// leaves on m_axis with the chosen face index in tuser. One result per pose.
// The camera-to-base pose and the six face offsets sit in registers on the
// APB port; write them only while no pose is in flight.
// Each pose passes through the 15-stage restoring divider that normalises
// both quaternions, plus the product, composition and position stages
// around it.
// One word per cycle unless the receiver stalls; each stage has a valid bit.
// When the receiver stalls, the finished word waits in the output register
// and the pipeline keeps accepting until its last stage is also full; then
// s_axis_tready drops and the whole pipeline holds, losing nothing.
// Reset clears all valid bits and sets the camera rotation to identity,
// translations and offsets to zero. The camera matrix follows a register
// write once the new rotation has crossed u_cam_mat, while the pipe drains.
// ----------------------------------------------------------------------------
module best_grasp_face_select
    import bgfs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // Pose input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // obj_quat_x, obj_quat_y, obj_quat_z, obj_quat_w (16 each),
    // obj_shift_x, obj_shift_y, obj_shift_z (20 each), zero pad
    input  logic [127:0] s_axis_tdata,
    // Result output
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dir_x, dir_y, dir_z (16 each), pos_x, pos_y, pos_z (20 each), zero pad
    output logic [111:0] m_axis_tdata,
    // face_index
    output logic [2:0]   m_axis_tuser
);

    localparam logic [2:0] REG_CAM_ROT = 3'd0;
    localparam logic [2:0] REG_CAM_SX  = 3'd1;
    localparam logic [2:0] REG_CAM_SY  = 3'd2;
    localparam logic [2:0] REG_CAM_SZ  = 3'd3;
    localparam logic [2:0] REG_OFF_LO  = 3'd4;
    localparam logic [2:0] REG_OFF_HI  = 3'd5;

    localparam int TOTAL = 1 + QM_LAT + CMP_LAT + FP_LAT;

    // Configuration registers.
    logic [63:0] r_cam_rot;
    t_len        r_cam_sx, r_cam_sy, r_cam_sz;
    logic [59:0] r_off_lo, r_off_hi;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_rot <= 64'h4000_0000_0000_0000;
            r_cam_sx  <= '0;
            r_cam_sy  <= '0;
            r_cam_sz  <= '0;
            r_off_lo  <= '0;
            r_off_hi  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_CAM_ROT: r_cam_rot <= pwdata;
                REG_CAM_SX:  r_cam_sx  <= pwdata[19:0];
                REG_CAM_SY:  r_cam_sy  <= pwdata[19:0];
                REG_CAM_SZ:  r_cam_sz  <= pwdata[19:0];
                REG_OFF_LO:  r_off_lo  <= pwdata[59:0];
                REG_OFF_HI:  r_off_hi  <= pwdata[59:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_CAM_ROT: prdata = r_cam_rot;
            REG_CAM_SX:  prdata = {44'd0, r_cam_sx};
            REG_CAM_SY:  prdata = {44'd0, r_cam_sy};
            REG_CAM_SZ:  prdata = {44'd0, r_cam_sz};
            REG_OFF_LO:  prdata = {4'd0, r_off_lo};
            REG_OFF_HI:  prdata = {4'd0, r_off_hi};
            default:     prdata = '0;
        endcase
    end

    // Pipeline flow control: the pipe moves unless its last stage is full and
    // the output register holds a word that the receiver does not take.
    logic             r_ovalid;
    logic [TOTAL-1:0] r_valid;
    logic             take;
    logic             en;

    assign take          = !r_ovalid || m_axis_tready;
    assign en            = take || !r_valid[TOTAL-1];
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[TOTAL-2:0], s_axis_tvalid};
        end
    end

    // Input register and the origin delay line.
    t_q16   r_in_q [4];
    t_vec3l r_in_t;
    t_vec3l r_td [QM_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r_in_q[k] <= s_axis_tdata[16*k +: 16];
            end
            for (int k = 0; k < 3; k++) begin
                r_in_t[k] <= s_axis_tdata[64 + 20*k +: 20];
            end
            r_td[0] <= r_in_t;
            for (int k = 1; k < QM_LAT; k++) begin
                r_td[k] <= r_td[k-1];
            end
        end
    end

    // Rotation matrices of the object and the camera.
    t_mat ro, rc;

    bgfs_quat_mat u_obj_mat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_in_q[0]),
        .i_y   (r_in_q[1]),
        .i_z   (r_in_q[2]),
        .i_w   (r_in_q[3]),
        .o_mat (ro)
    );

    bgfs_quat_mat u_cam_mat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_cam_rot[15:0]),
        .i_y   (r_cam_rot[31:16]),
        .i_z   (r_cam_rot[47:32]),
        .i_w   (r_cam_rot[63:48]),
        .o_mat (rc)
    );

    t_mat   rr;
    t_vec3a tsum;

    bgfs_compose u_compose (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ro   (ro),
        .i_rc   (rc),
        .i_tobj (r_td[QM_LAT-1]),
        .o_r    (rr),
        .o_tsum (tsum)
    );

    t_len       offs [6];
    t_vec3l     tcam;
    t_vec3q     dir;
    t_vec3l     pos;
    logic [2:0] face;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            offs[k]     = r_off_lo[20*k +: 20];
            offs[k + 3] = r_off_hi[20*k +: 20];
        end
        tcam[0] = r_cam_sx;
        tcam[1] = r_cam_sy;
        tcam[2] = r_cam_sz;
    end

    bgfs_face_pos u_face_pos (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_r    (rr),
        .i_tsum (tsum),
        .i_offs (offs),
        .i_tcam (tcam),
        .o_dir  (dir),
        .o_pos  (pos),
        .o_face (face)
    );

    // Output register.
    logic [111:0] r_odata;
    logic [2:0]   r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (take) begin
            r_ovalid <= r_valid[TOTAL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_odata <= {4'd0, pos[2], pos[1], pos[0], dir[2], dir[1], dir[0]};
            r_ouser <= face;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
`default_nettype wire

>>> hw/rtl/bgfs_quat_mat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgfs_quat_mat: pipelined quaternion to rotation matrix
// Products and squares, numerators, then a restoring divider with one quotient bit per
// stage for each of the nine entries. A zero quaternion gives the identity.
// ----------------------------------------------------------------------------
module bgfs_quat_mat
    import bgfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_q16 i_x,
    input  t_q16 i_y,
    input  t_q16 i_z,
    input  t_q16 i_w,
    output t_mat o_mat
);

    localparam int NL = 9;

    logic signed [SQ_W-1:0] r_pxx, r_pyy, r_pzz, r_pww, r_pxy;
    logic signed [SQ_W-1:0] r_pxz, r_pyz, r_pwx, r_pwy, r_pwz;

    // Stage one: all pairwise products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxx <= i_x * i_x;
            r_pyy <= i_y * i_y;
            r_pzz <= i_z * i_z;
            r_pww <= i_w * i_w;
            r_pxy <= i_x * i_y;
            r_pxz <= i_x * i_z;
            r_pyz <= i_y * i_z;
            r_pwx <= i_w * i_x;
            r_pwy <= i_w * i_y;
            r_pwz <= i_w * i_z;
        end
    end

    logic signed [NUM_W-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
    assign exx = NUM_W'(r_pxx);
    assign eyy = NUM_W'(r_pyy);
    assign ezz = NUM_W'(r_pzz);
    assign eww = NUM_W'(r_pww);
    assign exy = NUM_W'(r_pxy);
    assign exz = NUM_W'(r_pxz);
    assign eyz = NUM_W'(r_pyz);
    assign ewx = NUM_W'(r_pwx);
    assign ewy = NUM_W'(r_pwy);
    assign ewz = NUM_W'(r_pwz);

    logic signed [NUM_W-1:0] n_num [NL];
    logic [NORM_W-1:0]       n_norm;
    logic [REM_W-1:0]        n_rem0 [NL];
    logic [NL-1:0]           n_neg;

    // Stage two: norm, numerators and the initial partial remainders.
    always_comb begin
        logic signed [NUM_W-1:0] mag_v;
        n_norm   = NORM_W'(exx + eyy + ezz + eww);
        n_num[0] = eww + exx - eyy - ezz;
        n_num[1] = (exy - ewz) <<< 1;
        n_num[2] = (exz + ewy) <<< 1;
        n_num[3] = (exy + ewz) <<< 1;
        n_num[4] = eww - exx + eyy - ezz;
        n_num[5] = (eyz - ewx) <<< 1;
        n_num[6] = (exz - ewy) <<< 1;
        n_num[7] = (eyz + ewx) <<< 1;
        n_num[8] = eww - exx - eyy + ezz;
        for (int k = 0; k < NL; k++) begin
            n_neg[k]  = n_num[k][NUM_W-1];
            mag_v     = n_neg[k] ? -n_num[k] : n_num[k];
            n_rem0[k] = (REM_W'(mag_v) << DIV_STEPS) + REM_W'(n_norm);
        end
    end

    logic [REM_W-1:0]     r_rem  [DIV_STEPS+1][NL];
    logic [DIV_STEPS-1:0] r_quo  [DIV_STEPS+1][NL];
    logic [NL-1:0]        r_neg  [DIV_STEPS+1];
    logic [DVS_W-1:0]     r_dvs  [DIV_STEPS+1];
    logic                 r_zero [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NL; k++) begin
                r_rem[0][k] <= n_rem0[k];
                r_quo[0][k] <= '0;
            end
            r_neg[0]  <= n_neg;
            r_dvs[0]  <= {n_norm, 1'b0};
            r_zero[0] <= (n_norm == '0);
        end
    end

    // Divider stages: each settles one quotient bit, most significant first.
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        localparam int B = DIV_STEPS - 1 - s;
        logic [REM_W:0] trial [NL];

        always_comb begin
            for (int k = 0; k < NL; k++) begin
                trial[k] = {1'b0, r_rem[s][k]} - ((REM_W + 1)'(r_dvs[s]) << B);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < NL; k++) begin
                    if (!trial[k][REM_W]) begin
                        r_rem[s+1][k] <= trial[k][REM_W-1:0];
                        r_quo[s+1][k] <= {r_quo[s][k][DIV_STEPS-2:0], 1'b1};
                    end else begin
                        r_rem[s+1][k] <= r_rem[s][k];
                        r_quo[s+1][k] <= {r_quo[s][k][DIV_STEPS-2:0], 1'b0};
                    end
                end
                r_neg[s+1]  <= r_neg[s];
                r_dvs[s+1]  <= r_dvs[s];
                r_zero[s+1] <= r_zero[s];
            end
        end
    end

    t_mat r_mat;

    // Output stage: apply the sign, or the identity for a zero quaternion.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (r_zero[DIV_STEPS]) begin
                        r_mat[i][j] <= (i == j) ? Q_ONE : '0;
                    end else if (r_neg[DIV_STEPS][3*i+j]) begin
                        r_mat[i][j] <= -t_q16'(r_quo[DIV_STEPS][3*i+j]);
                    end else begin
                        r_mat[i][j] <= t_q16'(r_quo[DIV_STEPS][3*i+j]);
                    end
                end
            end
        end
    end

    assign o_mat = r_mat;

endmodule
`default_nettype wire

>>> hw/rtl/bgfs_compose.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgfs_compose: rotation composition and camera-frame origin transform
// Forms R = Rc * Ro rounded and clamped to unit range, and the unrounded
// sums Rc * t_obj for the position stage.
// ----------------------------------------------------------------------------
module bgfs_compose
    import bgfs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_mat   i_ro,
    input  t_mat   i_rc,
    input  t_vec3l i_tobj,
    output t_mat   o_r,
    output t_vec3a o_tsum
);

    logic signed [SQ_W-1:0] r_pm [3][3][3];
    logic signed [PT_W-1:0] r_pt [3][3];

    // Products of the matrix entries and of the object origin.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_pm[i][j][k] <= i_rc[i][k] * i_ro[k][j];
                    end
                    r_pt[i][k] <= i_rc[i][k] * i_tobj[k];
                end
            end
        end
    end

    t_mat   n_r, r_r;
    t_vec3a n_ts, r_ts;

    // Sums, rounding and clamping to plus or minus one.
    always_comb begin
        t_acc s;
        t_acc rs;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s  = t_acc'(r_pm[i][j][0]) + t_acc'(r_pm[i][j][1]) + t_acc'(r_pm[i][j][2]);
                rs = round_frac(s);
                if (rs > t_acc'(Q_ONE)) begin
                    n_r[i][j] = Q_ONE;
                end else if (rs < -t_acc'(Q_ONE)) begin
                    n_r[i][j] = -Q_ONE;
                end else begin
                    n_r[i][j] = t_q16'(rs);
                end
            end
            n_ts[i] = t_acc'(r_pt[i][0]) + t_acc'(r_pt[i][1]) + t_acc'(r_pt[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r  <= n_r;
            r_ts <= n_ts;
        end
    end

    assign o_r    = r_r;
    assign o_tsum = r_ts;

endmodule
`default_nettype wire

>>> hw/rtl/bgfs_face_pos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgfs_face_pos: face selection and grasp position
// Picks the face whose normal points most upward, then forms the approach
// direction and the saturated grasp position in the base frame.
// ----------------------------------------------------------------------------
module bgfs_face_pos
    import bgfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  t_mat       i_r,
    input  t_vec3a     i_tsum,
    input  t_len       i_offs [6],
    input  t_vec3l     i_tcam,
    output t_vec3q     o_dir,
    output t_vec3l     o_pos,
    output logic [2:0] o_face
);

    t_vec3q     n_dir, r_dir_a, r_dir_b, r_dir_c;
    logic [2:0] n_face, r_face_a, r_face_b, r_face_c;
    t_len       n_off, r_off_a;
    t_vec3a     r_ts_a, r_ts_b;

    // Face selection: strictly larger z wins, so the lowest index keeps a tie.
    always_comb begin
        t_q16 nz;
        t_q16 best;
        logic [1:0] col;
        best   = i_r[2][0];
        n_face = 3'd0;
        for (int f = 1; f < 6; f++) begin
            nz = f[0] ? -i_r[2][f>>1] : i_r[2][f>>1];
            if (nz > best) begin
                best   = nz;
                n_face = 3'(f);
            end
        end
        col = n_face[2:1];
        for (int i = 0; i < 3; i++) begin
            n_dir[i] = n_face[0] ? i_r[i][col] : -i_r[i][col];
        end
        n_off = i_offs[n_face];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dir_a  <= n_dir;
            r_face_a <= n_face;
            r_off_a  <= n_off;
            r_ts_a   <= i_tsum;
        end
    end

    logic signed [PT_W-1:0] r_pd [3];

    // Direction times the face offset.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pd[i] <= r_dir_a[i] * r_off_a;
            end
            r_dir_b  <= r_dir_a;
            r_face_b <= r_face_a;
            r_ts_b   <= r_ts_a;
        end
    end

    t_vec3l n_pos, r_pos;

    // Round, add the camera translation and saturate.
    always_comb begin
        t_acc p;
        for (int i = 0; i < 3; i++) begin
            p        = round_frac(t_acc'(r_pd[i]) + r_ts_b[i]) + t_acc'(i_tcam[i]);
            n_pos[i] = sat_len(p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos    <= n_pos;
            r_dir_c  <= r_dir_b;
            r_face_c <= r_face_b;
        end
    end

    assign o_dir  = r_dir_c;
    assign o_pos  = r_pos;
    assign o_face = r_face_c;

endmodule
`default_nettype wire
